// ----- rtl/core/cet_pkg.sv -----
package cet_pkg;

    localparam int SEED_LO_W   = 64;
    localparam int SEED_HI_W   = 60;
    localparam int SEED_W      = SEED_LO_W + SEED_HI_W;
    localparam int CUR_W       = 128;
    localparam int VALUE_BITS  = 124;
    localparam int SCALE_W     = 7;
    localparam int D_W         = 7;
    localparam int THR_W       = 12;
    localparam int K_W         = 6;
    localparam int EXIT_W      = 12;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int MAX_STEPS_DEFAULT = 4095;
    localparam int FRAC_BITS_DEFAULT = 48;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [THR_W-1:0] THRESHOLD_RESET    = '0;
    localparam logic             RESIDUE_MODE_RESET = 1'b0;
    localparam logic [K_W-1:0]   RESIDUE_BITS_RESET = 6'd20;

    // fractional part of log2(3), 60 bits, truncated
    localparam logic [59:0] LOG3_FRAC60 = 60'h95C01A39FBD687A;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_RESIDUE_MODE = 2'd1,
        CFG_RESIDUE_BITS = 2'd2
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXIT      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDECIDED = 2'd2,
        ST_STEP_CAP  = 2'd3
    } status_t;

    typedef struct packed {
        logic [SEED_HI_W-1:0] seed_hi;
        logic [SEED_LO_W-1:0] seed_lo;
    } cet_seed_t;

    typedef struct packed {
        logic [EXIT_W-1:0]   exit_steps;
        logic [STATUS_W-1:0] status;
        logic [SCALE_W-1:0]  scale;
    } cet_result_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic             residue_mode;
        logic [K_W-1:0]   residue_bits;
    } cet_cfg_t;

    typedef struct packed {
        logic [SEED_W-1:0]  value;
        logic [SCALE_W-1:0] scale;
    } cet_task_t;

    // log2(3) fraction rounded to nearest at frac_bits, right-aligned at bit 0
    function automatic logic [59:0] log3_frac(input int frac_bits);
        logic [60:0] r;
        r = {1'b0, LOG3_FRAC60} + (61'd1 << (59 - frac_bits));
        r = r >> (60 - frac_bits);
        return r[59:0];
    endfunction

    // trailing zero count, argument known nonzero
    function automatic logic [D_W-1:0] trail_zeros(input logic [CUR_W-1:0] x);
        logic [D_W-1:0] r;
        r = '0;
        for (int i = CUR_W - 1; i >= 0; i--) begin
            if (x[i]) r = D_W'(i);
        end
        return r;
    endfunction

    // index of highest set bit, 0 for zero
    function automatic logic [SCALE_W-1:0] top_bit(input logic [SEED_W-1:0] v);
        logic [SCALE_W-1:0] r;
        r = '0;
        for (int i = 0; i < SEED_W; i++) begin
            if (v[i]) r = SCALE_W'(i);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/collatz_exit_time.sv -----
// channel   dir  beat content                             handshake
// s_        in   cet_seed_t   {seed_hi, seed_lo}          s_valid / s_ready
// m_        out  cet_result_t {exit_steps, status, scale} m_valid / m_ready
// cfg_      in   cfg_index 0..2, cfg_data                 cfg_valid / cfg_ready
//
// each odd step of a seed runs through the states triple-and-add, trailing zero
// count, and shift and wall test, between an entry from idle and a finish hand-off
// the shared step loop in the back end sets the rate; the front end and queue
// take up to three further seeds while a run is in progress
// synchronous active-low reset clears handshake state and loads register defaults
// a stalled result beat waits in the output register while the next seed runs
module collatz_exit_time
    import cet_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cet_seed_t              s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cet_result_t            m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [THR_W-1:0] threshold_reg;
    logic             residue_mode_reg;
    logic [K_W-1:0]   residue_bits_reg;
    cet_cfg_t         cfg;

    // front end to queue, queue to back end
    logic      fq_valid;
    logic      fq_ready;
    cet_task_t fq_data;
    logic      qb_valid;
    logic      qb_ready;
    cet_task_t qb_data;

    // writes must land only while idle (the block does not enforce this), so no shadowing is needed
    assign cfg_ready        = 1'b1;
    assign cfg.threshold    = threshold_reg;
    assign cfg.residue_mode = residue_mode_reg;
    assign cfg.residue_bits = residue_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RESET;
            residue_mode_reg <= RESIDUE_MODE_RESET;
            residue_bits_reg <= RESIDUE_BITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[THR_W-1:0];
                CFG_RESIDUE_MODE: residue_mode_reg <= cfg_data[0];
                CFG_RESIDUE_BITS: residue_bits_reg <= cfg_data[K_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // seed masking and scale
    cet_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    // decouples classification from the step loop
    cet_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // syracuse iteration, wall test and result register
    cet_back #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // only a true exit carries a step count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_EXIT) |-> (m_data.exit_steps == '0))
        else $error("nonzero exit_steps on a non-exit result");

    // an exit needs at least one step, unless the count can wrap
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_EXIT) |->
            (MAX_STEPS > 4095 || m_data.exit_steps != '0))
        else $error("exit reported at step zero");

    // scale comes from a 124-bit seed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.scale <= SCALE_W'(SEED_W - 1)))
        else $error("scale beyond seed width");

    // input only stalls behind a beat held in the front stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> fq_valid)
        else $error("input stalled with empty front stage");

endmodule

// ----- rtl/core/cet_front.sv -----
module cet_front
    import cet_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cet_seed_t s_data,
    input  cet_cfg_t  cfg,
    output logic      q_valid,
    input  logic      q_ready,
    output cet_task_t q_data
);

    logic              valid_reg;
    cet_task_t         task_reg;
    cet_task_t         task_next;
    logic [SEED_W-1:0] seed;
    logic [SEED_LO_W-1:0] low_mask;

    assign seed     = {s_data.seed_hi, s_data.seed_lo};
    assign low_mask = ~({SEED_LO_W{1'b1}} << cfg.residue_bits);

    always_comb begin
        task_next.scale = top_bit(seed);
        if (cfg.residue_mode) begin
            task_next.value = {{SEED_HI_W{1'b0}}, s_data.seed_lo & low_mask};
        end else begin
            task_next.value = seed;
        end
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = task_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            task_reg <= task_next;
        end
    end

endmodule

// ----- rtl/core/cet_queue.sv -----
module cet_queue
    import cet_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  cet_task_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output cet_task_t rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cet_task_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/cet_back.sv -----
module cet_back
    import cet_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cet_cfg_t    cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  cet_task_t   q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output cet_result_t m_data
);

    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int WHOLE_W = STEP_W + 1;
    localparam int SUM_W   = ((WHOLE_W > THR_W) ? WHOLE_W : THR_W) + 2;
    localparam logic [FRAC_BITS-1:0] ALPHA = FRAC_BITS'(log3_frac(FRAC_BITS));

    typedef enum logic [2:0] {
        IDLE,
        TRIPLE,
        COUNT,
        APPLY,
        FINISH
    } state_t;

    state_t               state_reg;
    logic [CUR_W-1:0]     val_reg;
    logic [CUR_W-1:0]     x_reg;
    logic [D_W-1:0]       d_reg;
    logic [SUM_W-1:0]     s_reg;
    logic [STEP_W-1:0]    n_reg;
    logic [WHOLE_W-1:0]   whole_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [SCALE_W-1:0]   scale_reg;
    status_t              status_reg;
    logic                 out_valid_reg;
    cet_result_t          out_data_reg;

    logic [CUR_W-1:0]     x_next;
    logic [CUR_W-1:0]     val_next;
    logic [SUM_W-1:0]     s_next;
    logic [STEP_W-1:0]    n_next;
    logic [FRAC_BITS:0]   frac_next;
    logic [WHOLE_W-1:0]   whole_next;
    logic [SUM_W-1:0]     wall_level;
    logic                 res_stop;
    logic                 wall_hit;
    logic                 value_ovf;
    logic                 cap_hit;

    always_comb begin
        x_next     = val_reg + (val_reg << 1) + CUR_W'(1);
        val_next   = x_reg >> d_reg;
        s_next     = s_reg + SUM_W'(d_reg);
        n_next     = n_reg + 1'b1;
        frac_next  = {1'b0, frac_reg} + {1'b0, ALPHA};
        whole_next = whole_reg + WHOLE_W'(1) + WHOLE_W'(frac_next[FRAC_BITS]);
        wall_level = SUM_W'(whole_next) + SUM_W'(cfg.threshold);
        res_stop   = cfg.residue_mode && (s_next + SUM_W'(1) > SUM_W'(cfg.residue_bits));
        wall_hit   = s_next > wall_level;
        value_ovf  = val_next[CUR_W-1:VALUE_BITS] != '0;
        cap_hit    = n_next >= STEP_W'(MAX_STEPS);
    end

    assign q_ready = (state_reg == IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // finish reloads the output register itself
            if (out_valid_reg && m_ready && state_reg != FINISH) out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE: begin
                    if (q_valid) begin
                        val_reg   <= CUR_W'(q_data.value);
                        scale_reg <= q_data.scale;
                        s_reg     <= '0;
                        n_reg     <= '0;
                        whole_reg <= '0;
                        frac_reg  <= '0;
                        state_reg <= TRIPLE;
                    end
                end
                TRIPLE: begin
                    x_reg     <= x_next;
                    state_reg <= COUNT;
                end
                COUNT: begin
                    d_reg     <= trail_zeros(x_reg);
                    state_reg <= APPLY;
                end
                APPLY: begin
                    if (res_stop) begin
                        status_reg <= ST_UNDECIDED;
                        state_reg  <= FINISH;
                    end else begin
                        val_reg   <= val_next;
                        s_reg     <= s_next;
                        n_reg     <= n_next;
                        whole_reg <= whole_next;
                        frac_reg  <= frac_next[FRAC_BITS-1:0];
                        if (wall_hit) begin
                            status_reg <= ST_EXIT;
                            state_reg  <= FINISH;
                        end else if (value_ovf) begin
                            status_reg <= ST_OVERFLOW;
                            state_reg  <= FINISH;
                        end else if (cap_hit) begin
                            status_reg <= ST_STEP_CAP;
                            state_reg  <= FINISH;
                        end else begin
                            state_reg <= TRIPLE;
                        end
                    end
                end
                FINISH: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg           <= 1'b1;
                        out_data_reg.exit_steps <= (status_reg == ST_EXIT) ?
                                                   EXIT_W'(n_reg) : '0;
                        out_data_reg.status     <= status_reg;
                        out_data_reg.scale      <= scale_reg;
                        state_reg               <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/sv/collatz_exit_time_checker.sv -----
`timescale 1ns / 100ps

module collatz_exit_time_checker
    import cet_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  cet_seed_t              s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  cet_result_t            m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    // log2(3) fraction, rounded to nearest at FRAC_BITS
    localparam logic [60:0] LOG3_ROUNDED = {1'b0, LOG3_FRAC60} + (61'd1 << (59 - FRAC_BITS));
    localparam logic [63:0] FRAC_MASK    = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [63:0] LOG3_STEP    = 64'(LOG3_ROUNDED >> (60 - FRAC_BITS)) & FRAC_MASK;

    typedef struct packed {
        cet_seed_t   seed;
        cet_result_t res;
    } exit_due_t;

    exit_due_t        exits_due[$];
    exit_due_t        oldest;
    logic [THR_W-1:0] wall;
    logic             resid;
    logic [K_W-1:0]   kbits;

    // odd syracuse walk until the wall, overflow, residue limit or step cap
    function automatic cet_result_t syracuse_exit(input cet_seed_t seed,
                                                  input logic [THR_W-1:0] thr,
                                                  input logic res_mode,
                                                  input logic [K_W-1:0] k);
        logic [CUR_W-1:0]   val;
        logic [CUR_W-1:0]   x;
        int unsigned        d;
        int unsigned        sum;
        int unsigned        n;
        longint unsigned    whole;
        longint unsigned    frac;
        status_t            st;
        logic [SCALE_W-1:0] top;
        logic               found;
        logic               done;
        cet_result_t        r;
        top   = '0;
        found = 1'b0;
        for (int i = SEED_W - 1; i >= 0; i--) begin
            if (!found && seed[i]) begin
                top   = SCALE_W'(i);
                found = 1'b1;
            end
        end
        val = CUR_W'(seed);
        if (res_mode) val = val & ((CUR_W'(1) << k) - CUR_W'(1));
        sum   = 0;
        n     = 0;
        whole = 0;
        frac  = 0;
        done  = 1'b0;
        st    = ST_EXIT;
        while (!done) begin
            x = (val << 1) + val + CUR_W'(1);
            d = 0;
            while (!x[d]) d++;
            if (res_mode && (sum + d + 1 > k)) begin
                st   = ST_UNDECIDED;
                done = 1'b1;
            end else begin
                val   = x >> d;
                sum   = sum + d;
                n     = n + 1;
                frac  = frac + LOG3_STEP;
                whole = whole + 1 + (frac >> FRAC_BITS);
                frac  = frac & FRAC_MASK;
                if (longint'(sum) - longint'(thr) > longint'(whole)) begin
                    st   = ST_EXIT;
                    done = 1'b1;
                end else if ((val >> VALUE_BITS) != 0) begin
                    st   = ST_OVERFLOW;
                    done = 1'b1;
                end else if (n >= MAX_STEPS) begin
                    st   = ST_STEP_CAP;
                    done = 1'b1;
                end
            end
        end
        r.exit_steps = (st == ST_EXIT) ? EXIT_W'(n) : '0;
        r.status     = st;
        r.scale      = top;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            exits_due.delete();
            wall       = THRESHOLD_RESET;
            resid      = RESIDUE_MODE_RESET;
            kbits      = RESIDUE_BITS_RESET;
            mismatches = 0;
            pending    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (exits_due.size() == 0) begin
                    flag_mismatch($sformatf("result beat %h with no seed outstanding", m_data));
                end else begin
                    oldest = exits_due.pop_front();
                    if (m_data.exit_steps !== oldest.res.exit_steps)
                        flag_mismatch($sformatf("seed %h exit_steps %0d, want %0d", oldest.seed,
                                                m_data.exit_steps, oldest.res.exit_steps));
                    if (m_data.status !== oldest.res.status)
                        flag_mismatch($sformatf("seed %h status %0d, want %0d", oldest.seed,
                                                m_data.status, oldest.res.status));
                    if (m_data.scale !== oldest.res.scale)
                        flag_mismatch($sformatf("seed %h scale %0d, want %0d", oldest.seed,
                                                m_data.scale, oldest.res.scale));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_THRESHOLD:    wall  = cfg_data[THR_W-1:0];
                    CFG_RESIDUE_MODE: resid = cfg_data[0];
                    CFG_RESIDUE_BITS: kbits = cfg_data[K_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                exits_due.push_back({s_data, syracuse_exit(s_data, wall, resid, kbits)});
            pending = exits_due.size();
        end
    end

endmodule

// ----- tb/sv/collatz_exit_time_tb.sv -----
`timescale 1ns / 100ps

module collatz_exit_time_tb;
    import cet_pkg::*;

    // hang guard: time limit for the whole run, in ns
    localparam longint HANG_LIMIT_NS = 60_000_000;
    localparam int     RANDOM_SEEDS  = 1900;
    // index 3 is not a register, writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    cet_seed_t              s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    cet_result_t            m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int   mismatches;
    int   pending;
    // calm: neither side idles while this is set
    logic calm = 1'b0;

    collatz_exit_time dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts each result and compares
    collatz_exit_time_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 12 ns period
    always #6 aclk = ~aclk;

    // result side: stall about a quarter of the cycles, none while calm
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 24);
    end

    // hang guard
    initial begin
        #(HANG_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // idle cycles ahead of the next seed beat, geometric with ~24 % idle share
    function automatic int idle_gap();
        int g;
        g = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 24) g++;
        end
        return g;
    endfunction

    // mix of seed shapes so that exits, overflows and every scale turn up
    function automatic cet_seed_t rand_seed();
        logic [127:0]      raw;
        logic [SEED_W-1:0] v;
        int                pick;
        int                t;
        raw  = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 99);
        t    = $urandom_range(0, SEED_W - 1);
        if (pick < 40) begin
            // full width noise, mostly overflows
            v = raw[SEED_W-1:0];
        end else if (pick < 85) begin
            // random top bit, random below it
            v = (raw[SEED_W-1:0] & ((SEED_W'(1) << t) - SEED_W'(1))) | (SEED_W'(1) << t);
        end else if (pick < 92) begin
            v = SEED_W'($urandom_range(0, 1000));
        end else begin
            // run of ones: long climbing stretch
            v = (SEED_W'(1) << t) - SEED_W'(1);
        end
        return v;
    endfunction

    // one seed beat; entered and left at a falling edge, valid left high
    task automatic push_seed(input cet_seed_t v);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // every seed yields one result, so a short margin covers the hand-off
        repeat (4) @(negedge aclk);
    endtask

    // register write, only ever made with the block drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [THR_W-1:0]      wall;
        logic                  resid;
        logic [K_W-1:0]        kbits;
        logic [CFG_DATA_W-1:0] junk;
        int                    count;
        int                    pick;
        int                    rnd;
        rnd = 0;

        // synchronous reset held low, then released at a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: reset settings, wall 0, full seed ----
        push_seed({60'd0, 64'd0});                      // zero seed, scale 0
        push_seed({60'd0, 64'd1});                      // fixed point at 1
        push_seed({60'd0, 64'd2});                      // even seed
        push_seed({60'd0, 64'd27});
        push_seed({60'd0, 64'hFFFF_FFFF_FFFF_FFFF});    // low word full
        push_seed({60'd1, 64'd0});                      // 2^64, word boundary
        push_seed({60'hFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}); // top value
        push_seed({60'h800_0000_0000_0000, 64'd0});     // 2^123
        push_seed({60'h555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
        push_seed({60'hAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});

        // residue mode with the reset K of 20: only the low bits are walked
        write_reg(CFG_RESIDUE_MODE, 12'd1);
        push_seed({60'hFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        push_seed({60'd0, 64'd1});
        // K of zero gives undecided at once
        write_reg(CFG_RESIDUE_BITS, 12'd0);
        push_seed({60'd0, 64'd7});
        // widest K
        write_reg(CFG_RESIDUE_BITS, 12'd63);
        push_seed({60'd0, 64'hFFFF_FFFF_FFFF_FFFF});
        push_seed(rand_seed());
        write_reg(CFG_RESIDUE_BITS, 12'd1);
        push_seed({60'd0, 64'd1});

        // top wall: nothing exits before the step cap
        write_reg(CFG_RESIDUE_MODE, 12'd0);
        write_reg(CFG_THRESHOLD, 12'hFFF);
        push_seed({60'd0, 64'd1});
        push_seed({60'd0, 64'd0});

        // spare index must be ignored, spare data bits must be masked off
        write_reg(CFG_SPARE, 12'hFFF);
        write_reg(CFG_RESIDUE_MODE, 12'hFFE);
        write_reg(CFG_THRESHOLD, 12'd1);
        push_seed({60'd0, 64'd3});
        write_reg(CFG_THRESHOLD, 12'd40);
        push_seed(rand_seed());

        // ---- random phases, a fresh setting for each ----
        for (int phase = 0; rnd < RANDOM_SEEDS; phase++) begin
            calm = (phase >= 4 && phase < 7);
            pick = $urandom_range(0, 99);
            if (phase == 7) begin
                // step cap again, kept to two seeds as each can run all the way to the cap
                wall  = '1;
                count = 2;
            end else if (phase == 11) begin
                wall  = THR_W'($urandom_range(161, 1200));
                count = 2;
            end else begin
                // low walls keep runs short
                if (pick < 60)      wall = THR_W'($urandom_range(0, 12));
                else if (pick < 90) wall = THR_W'($urandom_range(13, 48));
                else                wall = THR_W'($urandom_range(49, 160));
                count = $urandom_range(40, 120);
            end
            resid = (phase != 7) && (phase != 11) && ($urandom_range(0, 99) < 30);
            kbits = ($urandom_range(0, 99) < 6) ? '0 : K_W'($urandom_range(1, 63));
            // odd phases carry noise in the unused data bits
            junk  = phase[0] ? CFG_DATA_W'($urandom) : '0;

            write_reg(CFG_THRESHOLD, wall);
            write_reg(CFG_RESIDUE_MODE, (junk & 12'hFFE) | CFG_DATA_W'(resid));
            write_reg(CFG_RESIDUE_BITS, (junk & 12'hFC0) | CFG_DATA_W'(kbits));
            if (phase == 2) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

            for (int j = 0; j < count && rnd < RANDOM_SEEDS; j++) begin
                push_seed(rand_seed());
                rnd++;
                // now and then the sender waits for a fully drained block
                if (j == 20 && (phase % 3) == 0) settle();
            end
        end

        // drain, then a margin for anything stray on the result side
        settle();
        repeat (16) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
